// ----- rtl/core/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the keypad scanner: opcodes, payload
// structs, key queue sizing and the control and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int QUEUE_DEPTH = 1;
  localparam int KEY_W       = 5;
  localparam int HOLD_W      = 3;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KEY_W-1:0]  NO_KEY       = 5'd16;
  localparam logic [HOLD_W-1:0] HOLD_ACCEPT  = 3'd2;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_SCAN   = 2'd0,
    OP_READ   = 2'd1,
    OP_LOCK   = 2'd2,
    OP_UNLOCK = 2'd3
  } op_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] row1_lines;
    logic [7:0] row2_lines;
  } in_t;

  typedef struct packed {
    key_t key_code;
    logic key_valid;
    key_t scanned_key;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic lock;
    logic unlock;
  } queue_ctrl_t;

  typedef struct packed {
    key_t head;
    logic read_enabled;
  } queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/kpd_decode.sv -----
// ----------------------------------------------------------------------------
// kpd_decode
// Priority encoder: picks one key from two active-low row bytes, group by
// group, highest cleared bit first within a nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_decode (
  input  wire logic [7:0]  row1_lines,
  input  wire logic [7:0]  row2_lines,
  output kpd_pkg::key_t    key
);
  import kpd_pkg::*;

  logic [3:0] nib [4];
  logic [3:0] hit;
  logic [1:0] rank [4];

  assign nib[0] = row1_lines[7:4];
  assign nib[1] = row1_lines[3:0];
  assign nib[2] = row2_lines[7:4];
  assign nib[3] = row2_lines[3:0];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      hit[g] = ~&nib[g];
      if (!nib[g][3]) begin
        rank[g] = 2'd0;
      end else if (!nib[g][2]) begin
        rank[g] = 2'd1;
      end else if (!nib[g][1]) begin
        rank[g] = 2'd2;
      end else begin
        rank[g] = 2'd3;
      end
    end
  end

  always_comb begin
    if (hit[0]) begin
      key = {3'd0, rank[0]};
    end else if (hit[1]) begin
      key = {3'd1, rank[1]};
    end else if (hit[2]) begin
      key = {3'd2, rank[2]};
    end else if (hit[3]) begin
      key = {3'd3, rank[3]};
    end else begin
      key = NO_KEY;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/kpd_debounce.sv -----
// ----------------------------------------------------------------------------
// kpd_debounce
// Hold counter per scanned key: flags a key as accepted on its second
// steady tick and every eighth steady tick after that.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_debounce (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          scan,
  input  wire kpd_pkg::key_t key,
  output logic               accept
);
  import kpd_pkg::*;

  key_t              last_key;
  logic [HOLD_W-1:0] hold_count;
  logic [HOLD_W-1:0] hold_count_next;
  logic              same;

  assign same            = (key == last_key);
  // wraps modulo eight, which gives the auto-repeat period
  assign hold_count_next = hold_count + 1'b1;
  assign accept          = scan && same && (key != NO_KEY) && (hold_count_next == HOLD_ACCEPT);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key   <= NO_KEY;
      hold_count <= '0;
    end else if (scan) begin
      if (!same) begin
        last_key   <= key;
        hold_count <= '0;
      end else if (key != NO_KEY) begin
        hold_count <= hold_count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/kpd_queue.sv -----
// ----------------------------------------------------------------------------
// kpd_queue
// Shift queue of accepted keys with fill count and read lock. New keys
// are dropped when full; unlock empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire kpd_pkg::queue_ctrl_t ctrl,
  input  wire kpd_pkg::key_t        key,
  output kpd_pkg::queue_stat_t      stat
);
  import kpd_pkg::*;

  key_t              key_queue [QUEUE_DEPTH];
  key_t              shifted   [QUEUE_DEPTH];
  logic [FILL_W-1:0] queue_fill;
  logic              read_enabled;
  logic              do_pop;

  assign do_pop            = ctrl.pop && read_enabled;
  assign stat.head         = key_queue[0];
  assign stat.read_enabled = read_enabled;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      shifted[i] = key_queue[i+1];
    end
    shifted[QUEUE_DEPTH-1] = NO_KEY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        key_queue[i] <= NO_KEY;
      end
      queue_fill   <= '0;
      read_enabled <= 1'b1;
    end else if (ctrl.unlock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        key_queue[i] <= NO_KEY;
      end
      queue_fill   <= '0;
      read_enabled <= 1'b1;
    end else if (ctrl.lock) begin
      read_enabled <= 1'b0;
    end else if (do_pop) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        key_queue[i] <= shifted[i];
      end
      if (queue_fill != '0) begin
        queue_fill <= queue_fill - 1'b1;
      end
    end else if (ctrl.push && (queue_fill < FILL_W'(QUEUE_DEPTH))) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (queue_fill == FILL_W'(i)) begin
          key_queue[i] <= key;
        end
      end
      queue_fill <= queue_fill + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/matrix_keypad_scan_debounce_top.sv -----
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_top
// Keypad scanner with debounce, auto-repeat and a key queue.
// ----------------------------------------------------------------------------
// One transfer on the input side gives exactly one transfer on the output
// side. Each item passes an input register and then a result register, so a
// result is offered once its item reaches the result register, and with
// out_ready held high a new item is taken every cycle. The debounce counter
// and the key queue are updated as an item moves from the input register into
// the result register, so items see state strictly in arrival order.
`default_nettype none

module matrix_keypad_scan_debounce_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire kpd_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output kpd_pkg::out_t     out_data
);
  import kpd_pkg::*;

  logic        s1_valid;
  in_t         s1_data;
  logic        out_en;
  logic        adv;
  key_t        scan_key;
  logic        accept;
  queue_ctrl_t qctrl;
  queue_stat_t qstat;
  out_t        res;

  assign out_en   = !out_valid || out_ready;
  assign adv      = s1_valid && out_en;
  assign in_ready = !s1_valid || out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  kpd_decode u_decode (
    .row1_lines (s1_data.row1_lines),
    .row2_lines (s1_data.row2_lines),
    .key        (scan_key)
  );

  kpd_debounce u_debounce (
    .clk    (clk),
    .rst    (rst),
    .scan   (adv && (s1_data.opcode == OP_SCAN)),
    .key    (scan_key),
    .accept (accept)
  );

  always_comb begin
    qctrl.push   = accept;
    qctrl.pop    = 1'b0;
    qctrl.lock   = 1'b0;
    qctrl.unlock = 1'b0;
    res.key_code    = NO_KEY;
    res.key_valid   = 1'b0;
    res.scanned_key = NO_KEY;
    case (s1_data.opcode)
      OP_SCAN: begin
        res.scanned_key = scan_key;
      end
      OP_READ: begin
        qctrl.pop = adv;
        if (qstat.read_enabled) begin
          res.key_code  = qstat.head;
          res.key_valid = (qstat.head != NO_KEY);
        end
      end
      OP_LOCK: begin
        qctrl.lock = adv;
      end
      OP_UNLOCK: begin
        qctrl.unlock = adv;
      end
      default: begin
      end
    endcase
  end

  kpd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (qctrl),
    .key  (scan_key),
    .stat (qstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/kpd_checker.sv -----
// ----------------------------------------------------------------------------
// kpd_checker
// Port-level checks on the keypad scanner's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire kpd_pkg::out_t out_data
);
  import kpd_pkg::*;

  // nothing is offered in the cycle after a reset edge
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_beep_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_valid |-> out_data.key_code != NO_KEY)
    else $error("key_valid without a key");

  // a result comes from either a scan or a read, never both
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.key_code == NO_KEY) || (out_data.scanned_key == NO_KEY))
    else $error("read and scan results in one transfer");

  // with the result register empty the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid |-> in_ready)
    else $error("input stalled with no result waiting");

endmodule

bind matrix_keypad_scan_debounce_top kpd_checker u_kpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
